>>> design/mrs_pkg.sv
`timescale 1ns / 1ps
package mrs_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CNT_W      = 17;
    localparam int SUM_W      = 41;
    localparam int SQ_W       = 63;
    localparam int MAG_W      = 40;
    localparam int WIDE_W     = 80;
    localparam int DEN_W      = 32;
    localparam int VAR_W      = 48;
    localparam int VAR_OUT_W  = 47;
    localparam int ROOT_W     = 24;
    localparam int STEP_W     = 7;

    localparam int DIV_STEPS     = WIDE_W;
    localparam int MUL_N_STEPS   = CNT_W;
    localparam int MUL_MAG_STEPS = MAG_W;
    localparam int ROOT_STEPS    = VAR_W / 2;

    localparam int MAX_LEN_DEF     = 65536;
    localparam int SAMPLE_BITS_DEF = 24;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACC,
        OP_MEAN_LD,
        OP_DIV_STEP,
        OP_MEAN_ST,
        OP_MUL_S2_LD,
        OP_MUL_ADD,
        OP_MUL_MAG_LD,
        OP_MUL_SUB,
        OP_VDIV_LD,
        OP_SDROOT_LD,
        OP_ROOT_STEP,
        OP_SEDIV_LD,
        OP_SEROOT_LD,
        OP_SE_SQR,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic single;
    } t_flags;

endpackage

>>> design/mrs_ctrl.sv
`timescale 1ns / 1ps
module mrs_ctrl
    import mrs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  logic   i_last_element,
    output logic   o_valid,
    input  logic   i_stall,
    input  t_flags i_flags,
    output t_cmd   o_cmd
);

    typedef enum logic [11:0] {
        S_ACC      = 12'b0000_0000_0001,
        S_MEAN_DIV = 12'b0000_0000_0010,
        S_MEAN_ST  = 12'b0000_0000_0100,
        S_MUL_SQ   = 12'b0000_0000_1000,
        S_MUL_MAG  = 12'b0000_0001_0000,
        S_VAR_DIV  = 12'b0000_0010_0000,
        S_SD_ROOT  = 12'b0000_0100_0000,
        S_SE_DIV   = 12'b0000_1000_0000,
        S_SE_ROOT  = 12'b0001_0000_0000,
        S_SE_SQR   = 12'b0010_0000_0000,
        S_SE_MUL   = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_ovalid, n_ovalid;

    assign o_valid = r_ovalid;
    assign o_stall = (r_state != S_ACC);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ovalid = r_ovalid & i_stall;
        o_cmd.op = OP_NOP;
        case (r_state)
            S_ACC: begin
                if (i_valid) begin
                    o_cmd.op = OP_ACC;
                    if (i_last_element) begin
                        n_state = S_MEAN_DIV;
                        n_step  = '0;
                    end
                end
            end
            S_MEAN_DIV: begin
                if (r_step == '0) begin
                    if (i_flags.empty) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.op = OP_MEAN_LD;
                        n_step   = r_step + 1'b1;
                    end
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                    if (r_step == STEP_W'(DIV_STEPS)) begin
                        n_state = S_MEAN_ST;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_MEAN_ST: begin
                o_cmd.op = OP_MEAN_ST;
                n_state  = i_flags.single ? S_DONE : S_MUL_SQ;
            end
            S_MUL_SQ: begin
                if (r_step == '0) begin
                    o_cmd.op = OP_MUL_S2_LD;
                    n_step   = r_step + 1'b1;
                end else begin
                    o_cmd.op = OP_MUL_ADD;
                    if (r_step == STEP_W'(MUL_N_STEPS)) begin
                        n_state = S_MUL_MAG;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_MUL_MAG: begin
                if (r_step == '0) begin
                    o_cmd.op = OP_MUL_MAG_LD;
                    n_step   = r_step + 1'b1;
                end else begin
                    o_cmd.op = OP_MUL_SUB;
                    if (r_step == STEP_W'(MUL_MAG_STEPS)) begin
                        n_state = S_VAR_DIV;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_VAR_DIV: begin
                if (r_step == '0) begin
                    o_cmd.op = OP_VDIV_LD;
                    n_step   = r_step + 1'b1;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                    if (r_step == STEP_W'(DIV_STEPS)) begin
                        n_state = S_SD_ROOT;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_SD_ROOT: begin
                if (r_step == '0) begin
                    o_cmd.op = OP_SDROOT_LD;
                    n_step   = r_step + 1'b1;
                end else begin
                    o_cmd.op = OP_ROOT_STEP;
                    if (r_step == STEP_W'(ROOT_STEPS)) begin
                        n_state = S_SE_DIV;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_SE_DIV: begin
                if (r_step == '0) begin
                    o_cmd.op = OP_SEDIV_LD;
                    n_step   = r_step + 1'b1;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                    if (r_step == STEP_W'(DIV_STEPS)) begin
                        n_state = S_SE_ROOT;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_SE_ROOT: begin
                if (r_step == '0) begin
                    o_cmd.op = OP_SEROOT_LD;
                    n_step   = r_step + 1'b1;
                end else begin
                    o_cmd.op = OP_ROOT_STEP;
                    if (r_step == STEP_W'(ROOT_STEPS)) begin
                        n_state = S_SE_SQR;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_SE_SQR: begin
                o_cmd.op = OP_SE_SQR;
                n_state  = S_SE_MUL;
                n_step   = '0;
            end
            S_SE_MUL: begin
                o_cmd.op = OP_MUL_ADD;
                if (r_step == STEP_W'(MUL_N_STEPS - 1)) begin
                    n_state = S_DONE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_ACC;
                    n_step   = '0;
                end
            end
            default: begin
                n_state = S_ACC;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

>>> design/mrs_dp.sv
`timescale 1ns / 1ps
module mrs_dp
    import mrs_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_is_missing,
    output t_flags                     o_flags,
    output logic                       o_status,
    output logic [CNT_W-1:0]           o_valid_count,
    output logic signed [SAMPLE_W-1:0] o_mean_value,
    output logic [VAR_OUT_W-1:0]       o_variance,
    output logic [ROOT_W-1:0]          o_std_dev,
    output logic [ROOT_W-1:0]          o_std_error,
    output logic signed [SAMPLE_W-1:0] o_minimum,
    output logic signed [SAMPLE_W-1:0] o_maximum
);

    // accumulators
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [SQ_W-1:0]            r_sq, n_sq;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;

    // shared arithmetic
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [WIDE_W-1:0]   r_p, n_p;
    logic [WIDE_W-1:0]   r_a, n_a;
    logic [MAG_W-1:0]    r_b, n_b;
    logic [DEN_W-1:0]    r_rem, n_rem;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [VAR_W-1:0]    r_sv, n_sv;
    logic [VAR_W-1:0]    r_res, n_res;
    logic [VAR_W-1:0]    r_bit, n_bit;
    logic [SAMPLE_W-1:0] r_mean, n_mean;
    logic [VAR_W-1:0]    r_var, n_var;
    logic [ROOT_W-1:0]   r_sd, n_sd;
    logic [ROOT_W-1:0]   r_se, n_se;

    // result registers
    logic                       r_o_status, n_o_status;
    logic [CNT_W-1:0]           r_o_cnt, n_o_cnt;
    logic signed [SAMPLE_W-1:0] r_o_mean, n_o_mean;
    logic [VAR_OUT_W-1:0]       r_o_var, n_o_var;
    logic [ROOT_W-1:0]          r_o_sd, n_o_sd;
    logic [ROOT_W-1:0]          r_o_se, n_o_se;
    logic signed [SAMPLE_W-1:0] r_o_min, n_o_min;
    logic signed [SAMPLE_W-1:0] r_o_max, n_o_max;

    logic signed [SAMPLE_BITS-1:0] x_raw;
    logic signed [SAMPLE_W-1:0]    x_ext;
    logic signed [2*SAMPLE_W-1:0]  x_sqr;
    logic                          take;
    logic signed [SUM_W-1:0]       sum_abs;
    logic [DEN_W:0]                div_t;
    logic                          div_ge;
    logic [DEN_W:0]                div_d;
    logic [WIDE_W-1:0]             mul_p;
    logic [VAR_W-1:0]              root_rb;
    logic                          root_ge;
    logic [VAR_W-1:0]              var_rnd;
    logic [ROOT_W-1:0]             sd_rnd;
    logic [ROOT_W:0]               se_odd;
    logic [2*ROOT_W+1:0]           se_sqr;
    logic [ROOT_W-1:0]             se_rnd;
    logic [2*CNT_W-1:0]            n_nm1;
    logic [VAR_W-1:0]              bit_init;
    logic [SAMPLE_W-1:0]           mean_q;

    assign x_raw = i_sample[SAMPLE_BITS-1:0];
    assign x_ext = SAMPLE_W'(x_raw);
    assign x_sqr = x_ext * x_ext;
    assign take  = !i_is_missing && (r_cnt < CNT_W'(MAX_LEN));

    assign sum_abs = r_sum[SUM_W-1] ? -r_sum : r_sum;

    assign div_t  = {r_rem, r_p[WIDE_W-1]};
    assign div_ge = div_t >= {1'b0, r_den};
    assign div_d  = div_t - {1'b0, r_den};

    assign mul_p = (i_cmd.op == OP_MUL_SUB) ? r_p - r_a : r_p + r_a;

    assign root_rb = r_res + r_bit;
    assign root_ge = r_sv >= root_rb;

    assign var_rnd  = r_p[VAR_W-1:0] + VAR_W'({r_rem, 1'b0} >= {1'b0, r_den});
    assign sd_rnd   = r_res[ROOT_W-1:0] + ROOT_W'(r_sv > r_res);
    assign se_odd   = {r_res[ROOT_W-1:0], 1'b1};
    assign se_sqr   = se_odd * se_odd;
    assign se_rnd   = r_se + ROOT_W'(WIDE_W'({r_var, 2'b00}) >= r_p);
    assign n_nm1    = r_cnt * (r_cnt - 1'b1);
    assign bit_init = VAR_W'(1) << (VAR_W - 2);
    assign mean_q   = r_p[SAMPLE_W-1:0];

    assign o_flags.empty  = (r_cnt == '0);
    assign o_flags.single = (r_cnt == CNT_W'(1));

    always_comb begin
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_sq   = r_sq;
        n_min  = r_min;
        n_max  = r_max;
        n_mag  = r_mag;
        n_neg  = r_neg;
        n_p    = r_p;
        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        n_den  = r_den;
        n_sv   = r_sv;
        n_res  = r_res;
        n_bit  = r_bit;
        n_mean = r_mean;
        n_var  = r_var;
        n_sd   = r_sd;
        n_se   = r_se;
        n_o_status = r_o_status;
        n_o_cnt    = r_o_cnt;
        n_o_mean   = r_o_mean;
        n_o_var    = r_o_var;
        n_o_sd     = r_o_sd;
        n_o_se     = r_o_se;
        n_o_min    = r_o_min;
        n_o_max    = r_o_max;
        case (i_cmd.op)
            OP_ACC: begin
                if (take) begin
                    n_cnt = r_cnt + 1'b1;
                    n_sum = r_sum + SUM_W'(x_ext);
                    n_sq  = r_sq + SQ_W'($unsigned(x_sqr));
                    if (r_cnt == '0 || x_ext < r_min) begin
                        n_min = x_ext;
                    end
                    if (r_cnt == '0 || x_ext > r_max) begin
                        n_max = x_ext;
                    end
                end
            end
            OP_MEAN_LD: begin
                n_mag = sum_abs[MAG_W-1:0];
                n_neg = r_sum[SUM_W-1];
                n_p   = WIDE_W'({sum_abs[MAG_W-1:0], 1'b0}) + WIDE_W'(r_cnt);
                n_den = DEN_W'({r_cnt, 1'b0});
                n_rem = '0;
            end
            OP_DIV_STEP: begin
                n_p   = {r_p[WIDE_W-2:0], div_ge};
                n_rem = div_ge ? div_d[DEN_W-1:0] : div_t[DEN_W-1:0];
            end
            OP_MEAN_ST: begin
                n_mean = r_neg ? -mean_q : mean_q;
            end
            OP_MUL_S2_LD: begin
                n_p = '0;
                n_a = WIDE_W'(r_sq);
                n_b = MAG_W'(r_cnt);
            end
            OP_MUL_MAG_LD: begin
                n_a = WIDE_W'(r_mag);
                n_b = r_mag;
            end
            OP_MUL_ADD, OP_MUL_SUB: begin
                if (r_b[0]) begin
                    n_p = mul_p;
                end
                n_a = {r_a[WIDE_W-2:0], 1'b0};
                n_b = r_b >> 1;
            end
            OP_VDIV_LD: begin
                n_den = n_nm1[DEN_W-1:0];
                n_rem = '0;
            end
            OP_SDROOT_LD: begin
                n_var = var_rnd;
                n_sv  = var_rnd;
                n_res = '0;
                n_bit = bit_init;
            end
            OP_ROOT_STEP: begin
                if (root_ge) begin
                    n_sv  = r_sv - root_rb;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
            end
            OP_SEDIV_LD: begin
                n_sd  = sd_rnd;
                n_p   = WIDE_W'(r_var);
                n_den = DEN_W'(r_cnt);
                n_rem = '0;
            end
            OP_SEROOT_LD: begin
                n_sv  = r_p[VAR_W-1:0];
                n_res = '0;
                n_bit = bit_init;
            end
            OP_SE_SQR: begin
                n_se = r_res[ROOT_W-1:0];
                n_a  = WIDE_W'(se_sqr);
                n_p  = '0;
                n_b  = MAG_W'(r_cnt);
            end
            OP_OUT: begin
                n_o_status = (r_cnt == '0);
                n_o_cnt    = r_cnt;
                n_o_min    = r_min;
                n_o_max    = r_max;
                n_o_mean   = (r_cnt == '0) ? '0 : r_mean;
                if (r_cnt < CNT_W'(2)) begin
                    n_o_var = '0;
                    n_o_sd  = '0;
                    n_o_se  = '0;
                end else begin
                    n_o_var = r_var[VAR_OUT_W-1:0];
                    n_o_sd  = r_sd;
                    n_o_se  = se_rnd;
                end
                n_cnt = '0;
                n_sum = '0;
                n_sq  = '0;
                n_min = '0;
                n_max = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_sq  <= '0;
            r_min <= '0;
            r_max <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
            r_sq  <= n_sq;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_p        <= n_p;
        r_a        <= n_a;
        r_b        <= n_b;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_sv       <= n_sv;
        r_res      <= n_res;
        r_bit      <= n_bit;
        r_mean     <= n_mean;
        r_var      <= n_var;
        r_sd       <= n_sd;
        r_se       <= n_se;
        r_o_status <= n_o_status;
        r_o_cnt    <= n_o_cnt;
        r_o_mean   <= n_o_mean;
        r_o_var    <= n_o_var;
        r_o_sd     <= n_o_sd;
        r_o_se     <= n_o_se;
        r_o_min    <= n_o_min;
        r_o_max    <= n_o_max;
    end

    assign o_status      = r_o_status;
    assign o_valid_count = r_o_cnt;
    assign o_mean_value  = r_o_mean;
    assign o_variance    = r_o_var;
    assign o_std_dev     = r_o_sd;
    assign o_std_error   = r_o_se;
    assign o_minimum     = r_o_min;
    assign o_maximum     = r_o_max;

endmodule

>>> design/masked_running_statistics.sv
`timescale 1ns / 1ps
// Running statistics over one vector of signed samples (12 fraction bits). Elements are
// taken one per cycle while o_stall is low; missing ones are skipped, and valid ones past
// MAX_LEN are ignored. The element flagged last closes the vector: the block then stalls
// its input while a bit-serial unit finishes the result, and the result register frees
// the input again as soon as the summary is loaded. For two or more valid elements the
// closing phase runs three 80-step restoring divisions (mean, variance, variance over
// count), two 24-step square roots and shift-add products of 17 and 40 steps; with one
// valid element it runs only the mean division, with none it skips to the result, and it
// waits longer while a previous summary still sits at the output. Count, mean, variance
// (n-1 divisor, 24 fraction bits), deviation, standard error, min and max come out
// rounded to nearest; an empty vector reports status 1 with all fields zero.
module masked_running_statistics
    import mrs_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_is_missing,
    input  logic                       i_last_element,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status,
    output logic [CNT_W-1:0]           o_valid_count,
    output logic signed [SAMPLE_W-1:0] o_mean_value,
    output logic [VAR_OUT_W-1:0]       o_variance,
    output logic [ROOT_W-1:0]          o_std_dev,
    output logic [ROOT_W-1:0]          o_std_error,
    output logic signed [SAMPLE_W-1:0] o_minimum,
    output logic signed [SAMPLE_W-1:0] o_maximum
);

    t_cmd   cmd;
    t_flags flags;

    mrs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .i_flags        (flags),
        .o_cmd          (cmd)
    );

    mrs_dp #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (i_sample),
        .i_is_missing  (i_is_missing),
        .o_flags       (flags),
        .o_status      (o_status),
        .o_valid_count (o_valid_count),
        .o_mean_value  (o_mean_value),
        .o_variance    (o_variance),
        .o_std_dev     (o_std_dev),
        .o_std_error   (o_std_error),
        .o_minimum     (o_minimum),
        .o_maximum     (o_maximum)
    );

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_valid_count == '0 && o_minimum == '0 && o_maximum == '0)
        else $error("empty result with nonzero fields");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> o_minimum <= o_maximum && o_valid_count != '0)
        else $error("minimum above maximum");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> o_mean_value >= o_minimum && o_mean_value <= o_maximum)
        else $error("mean outside sample range");

    a_single_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_count == CNT_W'(1) |->
            o_variance == '0 && o_std_dev == '0 && o_std_error == '0)
        else $error("spread nonzero for one sample");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mrs_pkg::*;

    typedef struct {
        logic                       status;
        logic [CNT_W-1:0]           valid_count;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [VAR_OUT_W-1:0]       variance;
        logic [ROOT_W-1:0]          std_dev;
        logic [ROOT_W-1:0]          std_error;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
    } t_summary;

    class stats_scoreboard;
        int unsigned  n_valid;
        longint       sum_x;
        logic [63:0]  sum_sq;
        longint       lo_x;
        longint       hi_x;
        bit           seen;
        t_summary     pending[$];
        int           errors;
        int           inputs_seen;
        int           summaries_checked;

        function void clear_vector();
            n_valid = 0;
            sum_x   = 0;
            sum_sq  = 0;
            lo_x    = 0;
            hi_x    = 0;
            seen    = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] sample, bit missing, bit last);
            t_summary     s;
            longint       x;
            logic [127:0] n;
            logic [127:0] mag;
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] q;
            logic [127:0] rem;
            logic [63:0]  var_v;
            logic [63:0]  sd;
            logic [63:0]  se;
            longint       mean;
            x = sample;
            inputs_seen++;
            if (!missing && n_valid < MAX_LEN_DEF) begin
                n_valid++;
                sum_x  += x;
                sum_sq += 64'(x * x);
                if (!seen || x < lo_x) lo_x = x;
                if (!seen || x > hi_x) hi_x = x;
                seen = 1;
            end
            if (!last) return;
            s = '{default: 0};
            if (n_valid == 0) begin
                s.status = 1;
            end else begin
                n   = n_valid;
                mag = (sum_x < 0) ? 128'(-sum_x) : 128'(sum_x);
                q   = (2 * mag + n) / (2 * n);
                mean = (sum_x < 0) ? -longint'(q) : longint'(q);
                var_v = 0;
                sd = 0;
                se = 0;
                if (n_valid >= 2) begin
                    num = n * 128'(sum_sq) - mag * mag;
                    den = n * (n - 1);
                    q   = num / den;
                    rem = num % den;
                    if (2 * rem >= den) q++;
                    var_v = q[63:0];
                    sd = int_sqrt(var_v);
                    if (var_v - sd * sd > sd) sd++;
                    se = int_sqrt(var_v / n_valid);
                    if (4 * 128'(var_v) >= n * (2 * 128'(se) + 1) * (2 * 128'(se) + 1)) se++;
                end
                s.valid_count = n_valid[CNT_W-1:0];
                s.mean_value  = mean[SAMPLE_W-1:0];
                s.variance    = var_v[VAR_OUT_W-1:0];
                s.std_dev     = sd[ROOT_W-1:0];
                s.std_error   = se[ROOT_W-1:0];
                s.minimum     = lo_x[SAMPLE_W-1:0];
                s.maximum     = hi_x[SAMPLE_W-1:0];
            end
            pending.push_back(s);
            clear_vector();
        endfunction

        function void check_result(t_summary got);
            t_summary e;
            if (pending.size() == 0) begin
                $error("unexpected summary transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            summaries_checked++;
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status); errors++;
            end
            if (got.valid_count !== e.valid_count) begin
                $error("valid_count: expected %0d, got %0d", e.valid_count, got.valid_count);
                errors++;
            end
            if (got.mean_value !== e.mean_value) begin
                $error("mean_value: expected %0d, got %0d", e.mean_value, got.mean_value);
                errors++;
            end
            if (got.variance !== e.variance) begin
                $error("variance: expected %0d, got %0d", e.variance, got.variance); errors++;
            end
            if (got.std_dev !== e.std_dev) begin
                $error("std_dev: expected %0d, got %0d", e.std_dev, got.std_dev); errors++;
            end
            if (got.std_error !== e.std_error) begin
                $error("std_error: expected %0d, got %0d", e.std_error, got.std_error);
                errors++;
            end
            if (got.minimum !== e.minimum) begin
                $error("minimum: expected %0d, got %0d", e.minimum, got.minimum); errors++;
            end
            if (got.maximum !== e.maximum) begin
                $error("maximum: expected %0d, got %0d", e.maximum, got.maximum); errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 0;
    logic                       i_rst_n = 0;
    logic                       i_valid = 0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample = 0;
    logic                       i_is_missing = 0;
    logic                       i_last_element = 0;
    logic                       o_valid;
    logic                       i_stall = 0;
    logic                       o_status;
    logic [CNT_W-1:0]           o_valid_count;
    logic signed [SAMPLE_W-1:0] o_mean_value;
    logic [VAR_OUT_W-1:0]       o_variance;
    logic [ROOT_W-1:0]          o_std_dev;
    logic [ROOT_W-1:0]          o_std_error;
    logic signed [SAMPLE_W-1:0] o_minimum;
    logic signed [SAMPLE_W-1:0] o_maximum;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    stats_scoreboard sb = new();

    masked_running_statistics dut (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_summary got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status      = o_status;
            got.valid_count = o_valid_count;
            got.mean_value  = o_mean_value;
            got.variance    = o_variance;
            got.std_dev     = o_std_dev;
            got.std_error   = o_std_error;
            got.minimum     = o_minimum;
            got.maximum     = o_maximum;
            sb.check_result(got);
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_elem(logic signed [SAMPLE_W-1:0] s, bit missing, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid        <= 1;
        i_sample       <= s;
        i_is_missing   <= missing;
        i_last_element <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(s, missing, last);
        @(negedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(4))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(8191))) - 24'sd4096;
            2: return ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
            3: return 24'($urandom_range(65535)) ^ {24{1'b1}};
            default: return 24'($urandom_range(1000));
        endcase
    endfunction

    task automatic random_vectors(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (int k = 0; k < len; k++) begin
                send_elem(rand_sample(), $urandom_range(99) < 20, k == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (400) @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed vectors
        send_elem(24'sh7fffff, 0, 0);
        send_elem(24'sh800000, 0, 0);
        send_elem(24'sh000000, 0, 1);
        send_elem(24'sh123456, 1, 1);
        send_elem(24'sh555555, 1, 0);
        send_elem(24'shaaaaaa, 1, 1);
        send_elem(24'sh800000, 0, 1);
        send_elem(24'sh7fffff, 0, 1);
        send_elem(24'sh001000, 0, 0);
        send_elem(24'sh7fffff, 1, 1);
        send_elem(24'shfff000, 0, 0);
        send_elem(24'shfff000, 0, 1);
        send_elem(-24'sd3, 0, 0);
        send_elem(24'sd2, 0, 0);
        send_elem(24'sd0, 0, 0);
        send_elem(24'sh555555, 0, 0);
        send_elem(24'shaaaaaa, 0, 1);
        send_elem(24'sd1, 0, 0);
        send_elem(24'sd2, 0, 1);

        send_idle_pct = 7;
        recv_idle_pct = 59;
        random_vectors(300);
        send_idle_pct = 59;
        recv_idle_pct = 7;
        random_vectors(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_vectors(300);
        drain();

        $display("covered %0d input transactions and %0d summaries, incl. empty, single",
                 sb.inputs_seen, sb.summaries_checked);
        $display("element and extreme-sample vectors under sender and receiver stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
